>>> rtl/ucw_pkg.sv
// ============================================================================
// ucw_pkg
// Shared types and constants for the Unicode cell width classifier.
// ============================================================================
`default_nettype none

package ucw_pkg;

    // Field widths.
    localparam int CP_W   = 21;
    localparam int IDX_W  = 9;
    localparam int CNT_W  = 10;
    localparam int CW_W   = 3;
    localparam int ENT_W  = 2 * CP_W;

    // Operation codes of an input word.
    localparam logic [1:0] OP_QUERY   = 2'd0;
    localparam logic [1:0] OP_WR_ZERO = 2'd1;
    localparam logic [1:0] OP_WR_WIDE = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_ZERO_COUNT = 1'b0;
    localparam logic CFG_WIDE_COUNT = 1'b1;

    // Result codes (signed two's complement).
    localparam logic signed [CW_W-1:0] W_CTRL   = -3'sd1;
    localparam logic signed [CW_W-1:0] W_ZERO   = 3'sd0;
    localparam logic signed [CW_W-1:0] W_NARROW = 3'sd1;
    localparam logic signed [CW_W-1:0] W_WIDE   = 3'sd2;

    // Outcome of the fixed classification stage.
    typedef enum logic [1:0] {
        CLS_ZERO,
        CLS_CTRL,
        CLS_SEARCH
    } cls_t;

    // Top level sequencer states.
    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_ZERO,
        TOP_WIDE,
        TOP_DONE
    } top_state_t;

    // Search engine states.
    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_FIRST,
        ENG_PROBE
    } eng_state_t;

    // Request from the sequencer to the search engine.
    typedef struct packed {
        logic            start;
        logic            sel_wide;
        logic [CP_W-1:0] cp;
    } eng_req_t;

    // Response from the search engine, valid for one cycle.
    typedef struct packed {
        logic done;
        logic hit;
    } eng_rsp_t;

    // Code points with a fixed answer that need no table lookup.
    function automatic cls_t fixed_class(input logic [CP_W-1:0] cp);
        cls_t cls;
        cls = CLS_SEARCH;
        if (cp == 21'h0 || cp == 21'h034F ||
            (cp >= 21'h200B && cp <= 21'h200F) ||
            cp == 21'h2028 || cp == 21'h2029 ||
            (cp >= 21'h202A && cp <= 21'h202E) ||
            (cp >= 21'h2060 && cp <= 21'h2063))
        begin
            cls = CLS_ZERO;
        end
        else if (cp < 21'd32 || (cp >= 21'h07F && cp < 21'h0A0))
        begin
            cls = CLS_CTRL;
        end
        return cls;
    endfunction

endpackage

`default_nettype wire

>>> rtl/ucw_ram.sv
// ============================================================================
// ucw_ram
// Simple dual-port synchronous RAM with one write and one registered read.
// ============================================================================
`default_nettype none

module ucw_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 42
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/ucw_search.sv
// ============================================================================
// ucw_search
// Binary search engine over one of two interval tables, one probe a cycle.
// ============================================================================
`default_nettype none

module ucw_search #(
    parameter int DEPTH = 512
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire ucw_pkg::eng_req_t            req,
    input  wire logic [$clog2(DEPTH):0]       count,
    input  wire logic [ucw_pkg::ENT_W-1:0]    zero_rdata,
    input  wire logic [ucw_pkg::ENT_W-1:0]    wide_rdata,
    output logic      [$clog2(DEPTH)-1:0]     raddr,
    output ucw_pkg::eng_rsp_t                 rsp
);

    import ucw_pkg::*;

    localparam int AW = $clog2(DEPTH);

    eng_state_t      state_reg, state_next;
    logic [AW:0]     lo_reg, lo_next;
    logic [AW:0]     hi_reg, hi_next;
    logic [AW-1:0]   mid_reg, mid_next;
    logic [CP_W-1:0] cp_reg, cp_next;
    logic            sel_reg, sel_next;
    logic            done_reg, done_next;
    logic            hit_reg, hit_next;

    logic [ENT_W-1:0] ent;
    logic [CP_W-1:0]  ent_start;
    logic [CP_W-1:0]  ent_end;
    logic             go_up;
    logic             go_down;
    logic             found;
    logic             below;
    logic [AW:0]      lo_upd;
    logic [AW:0]      hi_upd;
    logic [AW+1:0]    mid_sum;
    logic [AW-1:0]    mid_calc;
    logic             more;

    // Probe datapath: compare the entry read last cycle and narrow the window.
    always_comb
    begin
        ent       = sel_reg ? wide_rdata : zero_rdata;
        ent_start = ent[CP_W-1:0];
        ent_end   = ent[ENT_W-1:CP_W];
        go_up     = ent_end < cp_reg;
        go_down   = !go_up && (ent_start > cp_reg);
        found     = !go_up && !go_down;
        below     = cp_reg < ent_start;
        lo_upd    = lo_reg;
        hi_upd    = hi_reg;
        if (state_reg == ENG_PROBE)
        begin
            if (go_up)
            begin
                lo_upd = {1'b0, mid_reg} + (AW+1)'(1);
            end
            if (go_down)
            begin
                hi_upd = {1'b0, mid_reg};
            end
        end
        mid_sum  = (AW+2)'(lo_upd) + (AW+2)'(hi_upd) - (AW+2)'(1);
        mid_calc = mid_sum[AW:1];
        more     = lo_upd < hi_upd;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ENG_IDLE:
            begin
                if (req.start && count != '0)
                begin
                    state_next = ENG_FIRST;
                end
            end
            ENG_FIRST:
            begin
                state_next = below ? ENG_IDLE : ENG_PROBE;
            end
            ENG_PROBE:
            begin
                if (found || !more)
                begin
                    state_next = ENG_IDLE;
                end
            end
            default:
            begin
                state_next = ENG_IDLE;
            end
        endcase
    end

    // Outputs and datapath register updates.
    always_comb
    begin
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        mid_next  = mid_reg;
        cp_next   = cp_reg;
        sel_next  = sel_reg;
        done_next = 1'b0;
        hit_next  = 1'b0;
        raddr     = '0;
        case (state_reg)
            ENG_IDLE:
            begin
                // Entry 0 is read first to reject code points below the table.
                if (req.start)
                begin
                    lo_next   = '0;
                    hi_next   = count;
                    cp_next   = req.cp;
                    sel_next  = req.sel_wide;
                    done_next = (count == '0);
                end
            end
            ENG_FIRST:
            begin
                done_next = below;
                mid_next  = mid_calc;
                raddr     = mid_calc;
            end
            ENG_PROBE:
            begin
                done_next = found || !more;
                hit_next  = found;
                lo_next   = lo_upd;
                hi_next   = hi_upd;
                mid_next  = mid_calc;
                raddr     = mid_calc;
            end
            default:
            begin
                raddr = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ENG_IDLE;
            done_reg  <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            hit_reg   <= hit_next;
        end
    end

    // Search window registers.
    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        cp_reg  <= cp_next;
        sel_reg <= sel_next;
    end

    assign rsp.done = done_reg;
    assign rsp.hit  = hit_reg;

endmodule

`default_nettype wire

>>> rtl/unicode_char_cell_width.sv
// ============================================================================
// unicode_char_cell_width
// Terminal cell width of a Unicode code point from two loadable range tables.
// ============================================================================
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_stall  | op, code_point, entry_index, range_start,
//          |                      | range_end
//  out     | out_valid / out_stall| cell_width
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A write word does not stall the input; the next word is taken right after.
// A fixed-answer query goes through DONE into the output register once the output is
// free, and holds the input until then. A table query searches the zero-width table,
// then on a miss the wide table. A search reads entry 0 and then probes (up to
// clog2(count)+1); an empty table is not searched.
// The tables have no reset and are not cleared; counts reset to 1.
// A stalled output word holds; one further query may finish behind it.
// ============================================================================
`default_nettype none

module unicode_char_cell_width #(
    parameter int TABLE_DEPTH = 512
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    op,
    input  wire logic [ucw_pkg::CP_W-1:0]      code_point,
    input  wire logic [ucw_pkg::IDX_W-1:0]     entry_index,
    input  wire logic [ucw_pkg::CP_W-1:0]      range_start,
    input  wire logic [ucw_pkg::CP_W-1:0]      range_end,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [ucw_pkg::CW_W-1:0]    cell_width,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic                          cfg_index,
    input  wire logic [ucw_pkg::CNT_W-1:0]     cfg_data
);

    import ucw_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    top_state_t              state_reg, state_next;
    logic [CP_W-1:0]         cp_reg, cp_next;
    logic signed [CW_W-1:0]  res_reg, res_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [CW_W-1:0]  cell_width_reg, cell_width_next;
    logic [CNT_W-1:0]        zero_count_reg, wide_count_reg;

    logic             in_acc;
    logic             is_query;
    cls_t             cls;
    logic             out_free;
    logic             idx_ok;
    logic [AW-1:0]    waddr;
    logic [ENT_W-1:0] wdata;
    logic             we_zero;
    logic             we_wide;
    logic [AW:0]      zero_eff;
    logic [AW:0]      wide_eff;
    logic [AW:0]      eng_count;
    eng_req_t         eng_req;
    eng_rsp_t         eng_rsp;
    logic [AW-1:0]    raddr;
    logic [ENT_W-1:0] zero_rdata;
    logic [ENT_W-1:0] wide_rdata;

    // Handshake and input decode.
    assign in_stall  = (state_reg != TOP_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign is_query  = (op == OP_QUERY);
    assign cls       = fixed_class(code_point);
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    // Table writes go straight into the RAMs at the accepting edge.
    assign idx_ok  = 32'(entry_index) < 32'(TABLE_DEPTH);
    assign waddr   = AW'(entry_index);
    assign wdata   = {range_end, range_start};
    assign we_zero = in_acc && (op == OP_WR_ZERO) && idx_ok;
    assign we_wide = in_acc && (op == OP_WR_WIDE) && idx_ok;

    // Counts above the table depth saturate.
    assign zero_eff = (32'(zero_count_reg) > 32'(TABLE_DEPTH)) ?
                      (AW+1)'(TABLE_DEPTH) : (AW+1)'(zero_count_reg);
    assign wide_eff = (32'(wide_count_reg) > 32'(TABLE_DEPTH)) ?
                      (AW+1)'(TABLE_DEPTH) : (AW+1)'(wide_count_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            TOP_IDLE:
            begin
                if (in_acc && is_query)
                begin
                    state_next = (cls == CLS_SEARCH) ? TOP_ZERO : TOP_DONE;
                end
            end
            TOP_ZERO:
            begin
                if (eng_rsp.done)
                begin
                    state_next = eng_rsp.hit ? TOP_DONE : TOP_WIDE;
                end
            end
            TOP_WIDE:
            begin
                if (eng_rsp.done)
                begin
                    state_next = TOP_DONE;
                end
            end
            TOP_DONE:
            begin
                if (out_free)
                begin
                    state_next = TOP_IDLE;
                end
            end
            default:
            begin
                state_next = TOP_IDLE;
            end
        endcase
    end

    // Outputs: engine requests, result and output register.
    always_comb
    begin
        cp_next          = cp_reg;
        res_next         = res_reg;
        eng_req.start    = 1'b0;
        eng_req.sel_wide = 1'b0;
        eng_req.cp       = cp_reg;
        eng_count        = zero_eff;
        out_valid_next   = out_valid_reg && out_stall;
        cell_width_next  = cell_width_reg;
        case (state_reg)
            TOP_IDLE:
            begin
                if (in_acc && is_query)
                begin
                    cp_next  = code_point;
                    res_next = (cls == CLS_ZERO) ? W_ZERO : W_CTRL;
                    if (cls == CLS_SEARCH)
                    begin
                        eng_req.start = 1'b1;
                        eng_req.cp    = code_point;
                    end
                end
            end
            TOP_ZERO:
            begin
                if (eng_rsp.done)
                begin
                    if (eng_rsp.hit)
                    begin
                        res_next = W_ZERO;
                    end
                    else
                    begin
                        eng_req.start    = 1'b1;
                        eng_req.sel_wide = 1'b1;
                        eng_count        = wide_eff;
                    end
                end
            end
            TOP_WIDE:
            begin
                eng_count = wide_eff;
                if (eng_rsp.done)
                begin
                    res_next = eng_rsp.hit ? W_WIDE : W_NARROW;
                end
            end
            TOP_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    cell_width_next = res_reg;
                end
            end
            default:
            begin
                eng_count = zero_eff;
            end
        endcase
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= TOP_IDLE;
            out_valid_reg  <= 1'b0;
            zero_count_reg <= CNT_W'(1);
            wide_count_reg <= CNT_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_ZERO_COUNT)
                begin
                    zero_count_reg <= cfg_data;
                end
                else if (cfg_index == CFG_WIDE_COUNT)
                begin
                    wide_count_reg <= cfg_data;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cp_reg         <= cp_next;
        res_reg        <= res_next;
        cell_width_reg <= cell_width_next;
    end

    assign out_valid  = out_valid_reg;
    assign cell_width = cell_width_reg;

    // Zero-width interval table.
    ucw_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ENT_W)
    ) u_zero_ram (
        .clk   (clk),
        .we    (we_zero),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (zero_rdata)
    );

    // Wide interval table.
    ucw_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ENT_W)
    ) u_wide_ram (
        .clk   (clk),
        .we    (we_wide),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (wide_rdata)
    );

    // Shared binary search engine.
    ucw_search #(
        .DEPTH (TABLE_DEPTH)
    ) u_search (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (eng_req),
        .count      (eng_count),
        .zero_rdata (zero_rdata),
        .wide_rdata (wide_rdata),
        .raddr      (raddr),
        .rsp        (eng_rsp)
    );

endmodule

`default_nettype wire

>>> rtl/ucw_checker.sv
// ============================================================================
// ucw_checker
// Port-level checks for the cell width classifier, bound to the top level.
// ============================================================================
`default_nettype none

module ucw_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic [1:0]                    op,
    input wire logic [ucw_pkg::CP_W-1:0]      code_point,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic signed [ucw_pkg::CW_W-1:0] cell_width
);

    import ucw_pkg::*;

    // A stalled output word stays valid and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cell_width))
        else $error("output word changed while stalled");

    // Only the four defined width codes ever leave the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cell_width == W_CTRL || cell_width == W_ZERO ||
                       cell_width == W_NARROW || cell_width == W_WIDE))
        else $error("undefined width code on output");

    // A query occupies the block; a table write does not.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && op == OP_QUERY |=> in_stall)
        else $error("query did not occupy the block");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (op == OP_WR_ZERO || op == OP_WR_WIDE)
        |=> !in_stall)
        else $error("table write held the input");

    // A C0 control other than NUL, taken while the output is empty, passes through DONE into the output as -1.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && op == OP_QUERY && code_point != '0 &&
        code_point < CP_W'(32) && !out_valid
        |=> ##1 (out_valid && cell_width == W_CTRL))
        else $error("control character not reported as -1");

endmodule

bind unicode_char_cell_width ucw_checker u_ucw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .code_point (code_point),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cell_width (cell_width)
);

`default_nettype wire
